@@ design/dca_pkg.sv @@
// ----------------------------------------------------------------------------
// dca_pkg: shared types and constants for degree_centrality_argmax
// Field widths, register indexes, reset values and the controller state type.
// ----------------------------------------------------------------------------
package dca_pkg;

	// default store depth
	localparam int MAX_VERTICES_DEF = 1024;

	// field widths
	localparam int VERTEX_W = 10;
	localparam int WEIGHT_W = 16;
	localparam int SCORE_W  = 32;
	localparam int BEST_W   = 31;
	localparam int DELTA_W  = WEIGHT_W + 1;

	// configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_MODE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b1;

	localparam logic [CFG_W-1:0] VCOUNT_RESET = 11'd1024;

	// controller states, one-hot
	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_LAST  = 5'b10000
	} state_t;

endpackage

@@ design/degree_centrality_argmax.sv @@
// ----------------------------------------------------------------------------
// degree_centrality_argmax: most central vertex of a streamed graph
// Accumulates per-vertex scores from adjacency entries, then scans for the
// lowest-index vertex with the strictly greatest positive score.
// ----------------------------------------------------------------------------
// An adjacency entry transfers on any cycle with start high and busy low, so
// a graph streams in at one entry per cycle: each entry is one
// read-modify-write of its owner's score in the score memory, with the
// previous write forwarded when two entries hit the same vertex back to back.
// The entry flagged last raises busy through a drain state that retires the
// final write, a scan state with one memory read per vertex (the scan also
// zeroes every score it passes, so the store is clean for the next graph),
// and a last state that settles the compare. The result then appears for exactly
// one cycle with result_valid high and must be taken then; the receiver
// cannot stall it. After reset, busy stays high while a clearing pass zeroes
// the memory; configuration writes are taken at all times.
module degree_centrality_argmax #(
	parameter int MaxVertices = dca_pkg::MAX_VERTICES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// entry channel
	input  logic                                start,
	output logic                                busy,
	input  logic [dca_pkg::VERTEX_W-1:0]        owner_vertex,
	input  logic signed [dca_pkg::WEIGHT_W-1:0] edge_weight,
	input  logic                                last_entry,
	// result channel
	output logic                                result_valid,
	output logic [dca_pkg::VERTEX_W-1:0]        best_vertex,
	output logic [dca_pkg::BEST_W-1:0]          best_score,
	// configuration
	input  logic                                cfg_we,
	input  logic [dca_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dca_pkg::CFG_W-1:0]           cfg_data
);

	localparam int IdxW = $clog2(MaxVertices);
	localparam logic [IdxW-1:0] IdxLast = IdxW'(MaxVertices - 1);

	localparam logic signed [dca_pkg::SCORE_W-1:0] ScoreMax = 32'sh7FFF_FFFF;
	localparam logic signed [dca_pkg::SCORE_W-1:0] ScoreMin = 32'sh8000_0000;

	dca_pkg::state_t state_q;
	logic [IdxW-1:0] idx_q;

	logic                      mode_q;
	logic [dca_pkg::CFG_W-1:0] vcount_q;

	logic accept;

	// accumulate pipeline
	logic                                acc_valid_s1;
	logic [IdxW-1:0]                     acc_addr_s1;
	logic signed [dca_pkg::DELTA_W-1:0]  acc_delta_s1;
	logic                                wr_valid_s2;
	logic [IdxW-1:0]                     wr_addr_s2;
	logic signed [dca_pkg::SCORE_W-1:0]  wr_data_s2;

	// scan compare stage
	logic                                cmp_valid_s1;
	logic                                cmp_use_s1;
	logic [IdxW-1:0]                     cmp_idx_s1;
	logic signed [dca_pkg::SCORE_W-1:0]  run_score_q;
	logic [IdxW-1:0]                     run_vertex_q;
	logic signed [dca_pkg::SCORE_W-1:0]  run_score_nxt;
	logic [IdxW-1:0]                     run_vertex_nxt;

	// results
	logic                                res_valid_q;
	logic [dca_pkg::VERTEX_W-1:0]        res_vertex_q;
	logic [dca_pkg::BEST_W-1:0]          res_score_q;

	// memory ports
	logic                               mem_we;
	logic [IdxW-1:0]                    mem_waddr;
	logic [dca_pkg::SCORE_W-1:0]        mem_wdata;
	logic [IdxW-1:0]                    mem_raddr;
	logic [dca_pkg::SCORE_W-1:0]        mem_rdata;

	logic signed [dca_pkg::SCORE_W-1:0] acc_old;
	logic signed [dca_pkg::SCORE_W:0]   acc_sum;
	logic signed [dca_pkg::SCORE_W-1:0] acc_new;

	logic owner_ok;
	logic idx_ok;

	assign busy   = (state_q != dca_pkg::ST_IDLE);
	assign accept = start && !busy;

	// owner must lie below both the vertex count and the store depth
	assign owner_ok = (32'(owner_vertex) < 32'(vcount_q)) &&
	                  (32'(owner_vertex) < 32'(MaxVertices));
	assign idx_ok   = (32'(idx_q) < 32'(vcount_q));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			vcount_q <= dca_pkg::VCOUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dca_pkg::REG_SCORE_MODE:   mode_q   <= cfg_data[0];
				dca_pkg::REG_VERTEX_COUNT: vcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// controller and sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dca_pkg::ST_INIT;
			idx_q   <= '0;
		end else begin
			case (state_q)
				dca_pkg::ST_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IdxLast) begin
						idx_q   <= '0;
						state_q <= dca_pkg::ST_IDLE;
					end
				end
				dca_pkg::ST_IDLE: begin
					if (accept && last_entry) begin
						state_q <= dca_pkg::ST_DRAIN;
					end
				end
				dca_pkg::ST_DRAIN: begin
					idx_q   <= '0;
					state_q <= dca_pkg::ST_SCAN;
				end
				dca_pkg::ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IdxLast) begin
						idx_q   <= '0;
						state_q <= dca_pkg::ST_LAST;
					end
				end
				dca_pkg::ST_LAST: begin
					state_q <= dca_pkg::ST_IDLE;
				end
				default: begin
					state_q <= dca_pkg::ST_INIT;
					idx_q   <= '0;
				end
			endcase
		end
	end

	// entry transfer: latch address and increment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_valid_s1 <= 1'b0;
			wr_valid_s2  <= 1'b0;
		end else begin
			acc_valid_s1 <= accept && owner_ok;
			wr_valid_s2  <= acc_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		acc_addr_s1  <= IdxW'(owner_vertex);
		acc_delta_s1 <= mode_q ? (dca_pkg::DELTA_W'(edge_weight) + 17'sd1) : 17'sd1;
		wr_addr_s2   <= acc_addr_s1;
		wr_data_s2   <= acc_new;
	end

	// forward the write that landed on the same edge as this read
	assign acc_old = (wr_valid_s2 && (wr_addr_s2 == acc_addr_s1)) ?
	                 wr_data_s2 : $signed(mem_rdata);

	// saturating add
	always_comb begin
		acc_sum = 33'(acc_old) + 33'(acc_delta_s1);
		if (acc_sum[dca_pkg::SCORE_W] != acc_sum[dca_pkg::SCORE_W-1]) begin
			acc_new = acc_sum[dca_pkg::SCORE_W] ? ScoreMin : ScoreMax;
		end else begin
			acc_new = acc_sum[dca_pkg::SCORE_W-1:0];
		end
	end

	// memory port steering: sweeps write zeros, otherwise the accumulator writes
	always_comb begin
		mem_we    = acc_valid_s1;
		mem_waddr = acc_addr_s1;
		mem_wdata = acc_new;
		mem_raddr = IdxW'(owner_vertex);
		case (state_q)
			dca_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = '0;
			end
			dca_pkg::ST_SCAN: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = '0;
				mem_raddr = idx_q;
			end
			default: ;
		endcase
	end

	dca_score_mem #(
		.Depth (MaxVertices),
		.AddrW (IdxW),
		.DataW (dca_pkg::SCORE_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// scan compare: only a strictly greater score replaces the running best
	always_comb begin
		run_score_nxt  = run_score_q;
		run_vertex_nxt = run_vertex_q;
		if (cmp_valid_s1 && cmp_use_s1 && ($signed(mem_rdata) > run_score_q)) begin
			run_score_nxt  = $signed(mem_rdata);
			run_vertex_nxt = cmp_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_valid_s1 <= 1'b0;
		end else begin
			cmp_valid_s1 <= (state_q == dca_pkg::ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		cmp_use_s1 <= idx_ok;
		cmp_idx_s1 <= idx_q;
		if (state_q == dca_pkg::ST_DRAIN) begin
			run_score_q  <= '0;
			run_vertex_q <= '0;
		end else begin
			run_score_q  <= run_score_nxt;
			run_vertex_q <= run_vertex_nxt;
		end
	end

	// result strobe, one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == dca_pkg::ST_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dca_pkg::ST_LAST) begin
			res_vertex_q <= dca_pkg::VERTEX_W'(run_vertex_nxt);
			res_score_q  <= run_score_nxt[dca_pkg::BEST_W-1:0];
		end
	end

	assign result_valid = res_valid_q;
	assign best_vertex  = res_vertex_q;
	assign best_score   = res_score_q;

endmodule

@@ design/dca_score_mem.sv @@
// ----------------------------------------------------------------------------
// dca_score_mem: per-vertex score store
// Synchronous memory, one write and one read port, registered read data,
// read-before-write on a same-address collision.
// ----------------------------------------------------------------------------
module dca_score_mem #(
	parameter int Depth = dca_pkg::MAX_VERTICES_DEF,
	parameter int AddrW = $clog2(Depth),
	parameter int DataW = dca_pkg::SCORE_W
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [DataW-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [DataW-1:0] rdata
);

	logic [DataW-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/dca_checker.sv @@
// ----------------------------------------------------------------------------
// dca_checker: port-level checks for degree_centrality_argmax
// Watches the entry and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module dca_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         last_entry,
	input logic                         result_valid,
	input logic [dca_pkg::VERTEX_W-1:0] best_vertex,
	input logic [dca_pkg::BEST_W-1:0]   best_score
);

	// result strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held past one cycle");

	// a last-entry transfer starts the scan
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && last_entry) |=> busy)
		else $error("no scan after last entry");

	// an ordinary entry never yields a result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !last_entry) |=> !result_valid)
		else $error("result without last entry");

	// the block is free again when its result shows
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("busy during result strobe");

	// no positive score means vertex zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (best_score == '0)) |-> (best_vertex == '0))
		else $error("nonzero vertex with zero score");

endmodule

bind degree_centrality_argmax dca_checker u_dca_checker (.*);

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for degree_centrality_argmax
// Streams adjacency entries through the entry channel, predicts the best vertex
// and score of every graph, and checks each result strobe against the oldest
// pending prediction. Covers directed corner graphs and random graphs under
// changing score modes and vertex counts.
// ----------------------------------------------------------------------------
module testbench;
	import dca_pkg::*;

	localparam int STORE_DEPTH  = MAX_VERTICES_DEF;
	localparam int RANDOM_ITEMS = 1550;
	localparam int CYCLE_LIMIT  = 12000000;
	localparam int SETTLE       = 4;
	localparam int FINAL_SETTLE = STORE_DEPTH + 16;

	typedef struct packed {
		logic [VERTEX_W-1:0] vertex;
		logic [BEST_W-1:0]   score;
	} best_t;

	// Predicts per-graph argmax and holds the results still to come
	class centrality_board;
		int                 score_of [STORE_DEPTH];
		bit                 mode_weighted;
		logic [CFG_W-1:0]   count_reg;
		best_t              pending_best [$];
		int                 mismatches;

		function new();
			mode_weighted = 1'b0;
			count_reg = VCOUNT_RESET;
			mismatches = 0;
			foreach (score_of[i]) score_of[i] = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_SCORE_MODE) mode_weighted = data[0];
			else count_reg = data;
		endfunction

		function int pending();
			return pending_best.size();
		endfunction

		// one accepted entry: accumulate, and on the last entry scan and clear
		function void add_entry(logic [VERTEX_W-1:0] owner, logic signed [WEIGHT_W-1:0] w,
				logic last);
			int     active;
			int     delta;
			longint sum;
			int     best_s;
			int     best_v;
			best_t  b;
			active = (count_reg > STORE_DEPTH) ? STORE_DEPTH : int'(count_reg);
			if (int'(owner) < active) begin
				delta = mode_weighted ? 1 + int'(w) : 1;
				sum = longint'(score_of[owner]) + longint'(delta);
				if (sum > 64'sd2147483647) sum = 64'sd2147483647;
				if (sum < -64'sd2147483648) sum = -64'sd2147483648;
				score_of[owner] = int'(sum);
			end
			if (last) begin
				best_s = 0;
				best_v = 0;
				// strictly greater only, so ties keep the lowest index
				for (int i = 0; i < active; i++) begin
					if (score_of[i] > best_s) begin
						best_s = score_of[i];
						best_v = i;
					end
				end
				b.vertex = best_v[VERTEX_W-1:0];
				b.score = best_s[BEST_W-1:0];
				pending_best.push_back(b);
				foreach (score_of[i]) score_of[i] = 0;
			end
		endfunction

		function void check_best(logic [VERTEX_W-1:0] v, logic [BEST_W-1:0] s);
			best_t e;
			if (pending_best.size() == 0) begin
				$display("%0t: unexpected result: vertex %0d score %0d", $time, v, s);
				mismatches++;
			end else begin
				e = pending_best.pop_front();
				if (v !== e.vertex) begin
					$display("%0t: best_vertex mismatch: expected %0d, actual %0d",
						$time, e.vertex, v);
					mismatches++;
				end
				if (s !== e.score) begin
					$display("%0t: best_score mismatch: expected %0d, actual %0d",
						$time, e.score, s);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [VERTEX_W-1:0]        owner_vertex;
	logic signed [WEIGHT_W-1:0] edge_weight;
	logic                       last_entry;
	logic                       result_valid;
	logic [VERTEX_W-1:0]        best_vertex;
	logic [BEST_W-1:0]          best_score;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;

	centrality_board board;
	int              cycle_count = 0;
	int              random_count = 0;
	logic [CFG_W-1:0] cur_count;

	degree_centrality_argmax dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.owner_vertex (owner_vertex),
		.edge_weight  (edge_weight),
		.last_entry   (last_entry),
		.result_valid (result_valid),
		.best_vertex  (best_vertex),
		.best_score   (best_score),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// result monitor: every strobe is a transfer the receiver must take
	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1) board.check_best(best_vertex, best_score);
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// register write; the task does not wait for busy to fall
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		board.set_reg(idx, data);
		if (idx == REG_VERTEX_COUNT) cur_count = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one entry transfer, with an optional idle gap ahead of it
	task automatic send_entry(input logic [VERTEX_W-1:0] owner,
			input logic signed [WEIGHT_W-1:0] w, input logic last, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		owner_vertex = owner;
		edge_weight = w;
		last_entry = last;
		do @(posedge clk); while (busy !== 1'b0);
		board.add_entry(owner, w, last);
	endtask

	// hold off the sender until every pending result has arrived
	task automatic wait_drained(input int settle);
		@(negedge clk);
		start = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [CFG_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return '0;
		if (r < 15) return 11'd1;
		if (r < 20) return 11'd2;
		if (r < 30) return 11'd1024;
		if (r < 35) return 11'd2047;
		if (r < 42) return 11'($urandom_range(1025, 2047));
		if (r < 75) return 11'($urandom_range(3, 32));
		return 11'($urandom_range(33, 1023));
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return WEIGHT_W'($urandom_range(0, 20) - 10);
		if (r < 80) return WEIGHT_W'($urandom);
		if (r < 90) return 16'sh7FFF;
		return 16'sh8000;
	endfunction

	// random graph: half the owners from a small hot set to force close contests
	task automatic random_graph();
		int active;
		int len;
		int r;
		int gap;
		bit burst;
		logic [VERTEX_W-1:0] owner;
		logic [VERTEX_W-1:0] pool [4];
		active = (cur_count > STORE_DEPTH) ? STORE_DEPTH : int'(cur_count);
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
		burst = ($urandom_range(0, 3) == 0);
		foreach (pool[k]) pool[k] = (active > 0) ? VERTEX_W'($urandom_range(0, active - 1)) : '0;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (active > 0 && r < 50) owner = pool[$urandom_range(0, 3)];
			else if (active > 0 && r < 80) owner = VERTEX_W'($urandom_range(0, active - 1));
			else owner = VERTEX_W'($urandom);
			gap = burst ? 0 : pick_gap();
			send_entry(owner, pick_weight(), i == len - 1, gap);
			random_count++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		owner_vertex = '0;
		edge_weight = '0;
		last_entry = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SCORE_MODE;
		cfg_data = '0;
		cur_count = VCOUNT_RESET;
		board = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes and ties in plain mode
		write_reg(REG_SCORE_MODE, 11'd0);
		write_reg(REG_VERTEX_COUNT, 11'd1024);
		send_entry(10'd0, 16'sh7FFF, 1'b0, 0);
		send_entry(10'd1023, 16'sh8000, 1'b0, 0);
		send_entry(10'd0, -16'sd1, 1'b0, 0);
		send_entry(10'd1023, 16'sd0, 1'b1, 0);
		send_entry(10'd512, 16'sd0, 1'b1, 2);
		wait_drained(SETTLE);

		// weighted mode: no positive score, then a weighted tie
		write_reg(REG_SCORE_MODE, 11'd1);
		send_entry(10'd3, 16'sh8000, 1'b0, 0);
		send_entry(10'd4, -16'sd1, 1'b0, 1);
		send_entry(10'd5, -16'sd2, 1'b1, 0);
		send_entry(10'd6, 16'sh7FFF, 1'b0, 0);
		send_entry(10'd2, 16'sh7FFF, 1'b1, 0);
		wait_drained(SETTLE);

		// owners out of range, last flag on an ignored entry
		write_reg(REG_VERTEX_COUNT, 11'd10);
		send_entry(10'd10, 16'sd100, 1'b0, 0);
		send_entry(10'd9, 16'sd5, 1'b0, 0);
		send_entry(10'd1023, 16'sh7FFF, 1'b1, 0);
		wait_drained(SETTLE);

		// vertex count zero
		write_reg(REG_VERTEX_COUNT, 11'd0);
		send_entry(10'd0, 16'sd50, 1'b1, 0);
		wait_drained(SETTLE);

		// vertex count above the store depth
		write_reg(REG_VERTEX_COUNT, 11'd2047);
		send_entry(10'd1023, 16'sd7, 1'b1, 0);
		wait_drained(SETTLE);

		// single vertex
		write_reg(REG_VERTEX_COUNT, 11'd1);
		send_entry(10'd1, 16'sd9, 1'b0, 0);
		send_entry(10'd0, 16'sd9, 1'b1, 0);
		wait_drained(SETTLE);

		// random phases, each with its own setting; drained before each change
		while (random_count < RANDOM_ITEMS) begin
			write_reg(REG_SCORE_MODE, 11'($urandom_range(0, 1)));
			write_reg(REG_VERTEX_COUNT, pick_count());
			repeat ($urandom_range(2, 6)) random_graph();
			wait_drained(SETTLE);
		end

		wait_drained(FINAL_SETTLE);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/dca_pkg.sv
design/dca_score_mem.sv
design/degree_centrality_argmax.sv
design/dca_checker.sv
test/testbench.sv
